@@ design/assert_macros.svh @@
// Assertion helpers shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ design/iir_df2_pkg.sv @@
package iir_df2_pkg;

  // Widths of the fixed-point words
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int STATE_W  = 40;
  localparam int ORDER_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_FB   = 4;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB3    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE = 3'd6;

  // Reset values
  localparam logic [ORDER_W-1:0]  ORDER_RST  = 3'd2;
  localparam logic [COEF_W-1:0]   SCALE_RST  = 24'h10_0000;  // 1.0 in Q4.20
  localparam logic [SAMPLE_W-1:0] MIDDLE_RST = 16'd2;

  // Order limits; order four uses the fixed binomial numerator
  localparam logic [ORDER_W-1:0] ORDER_MIN  = 3'd2;
  localparam logic [ORDER_W-1:0] ORDER_FULL = 3'd4;

  // Saturation bounds of the state word, Q24.16
  localparam logic signed [47:0] W_MAX = 48'sh00_7F_FFFF_FFFF;
  localparam logic signed [47:0] W_MIN = -48'sh00_80_0000_0000;

  // Saturation bounds of the output sample
  localparam logic signed [42:0] Y_MAX = 43'sd32767;
  localparam logic signed [42:0] Y_MIN = -43'sd32768;

  // Decoded configuration, effective order already clamped
  typedef struct packed {
    logic [ORDER_W-1:0]             order;
    logic [COEF_W-1:0]              input_scale;
    logic [NUM_FB-1:0][COEF_W-1:0]  fb_coef;
    logic [SAMPLE_W-1:0]            middle_tap;
  } cfg_t;

  // Delay taps before the shift, plus the new state value w
  typedef struct packed {
    logic [NUM_FB-1:0][STATE_W-1:0] d;
    logic [STATE_W-1:0]             w;
  } stage_t;

endpackage

@@ design/iir_df2_cfg.sv @@
module iir_df2_cfg #(
  parameter int NTAP = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [iir_df2_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iir_df2_pkg::COEF_W-1:0]       cfg_wdata,
  output iir_df2_pkg::cfg_t                    cfg
);

  logic [iir_df2_pkg::ORDER_W-1:0]                          order_raw;
  logic [iir_df2_pkg::COEF_W-1:0]                           input_scale;
  logic [iir_df2_pkg::NUM_FB-1:0][iir_df2_pkg::COEF_W-1:0]  fb_coef;
  logic [iir_df2_pkg::SAMPLE_W-1:0]                         middle_tap;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      order_raw   <= iir_df2_pkg::ORDER_RST;
      input_scale <= iir_df2_pkg::SCALE_RST;
      fb_coef     <= '0;
      middle_tap  <= iir_df2_pkg::MIDDLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iir_df2_pkg::REG_ORDER:  order_raw   <= cfg_wdata[iir_df2_pkg::ORDER_W-1:0];
        iir_df2_pkg::REG_SCALE:  input_scale <= cfg_wdata;
        iir_df2_pkg::REG_FB0:    fb_coef[0]  <= cfg_wdata;
        iir_df2_pkg::REG_FB1:    fb_coef[1]  <= cfg_wdata;
        iir_df2_pkg::REG_FB2:    fb_coef[2]  <= cfg_wdata;
        iir_df2_pkg::REG_FB3:    fb_coef[3]  <= cfg_wdata;
        iir_df2_pkg::REG_MIDDLE: middle_tap  <= cfg_wdata[iir_df2_pkg::SAMPLE_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Clamp order into [2, NTAP]
  always_comb begin
    cfg.input_scale = input_scale;
    cfg.fb_coef     = fb_coef;
    cfg.middle_tap  = middle_tap;
    priority if (order_raw < iir_df2_pkg::ORDER_MIN) begin
      cfg.order = iir_df2_pkg::ORDER_MIN;
    end else if (order_raw > iir_df2_pkg::ORDER_W'(NTAP)) begin
      cfg.order = iir_df2_pkg::ORDER_W'(NTAP);
    end else begin
      cfg.order = order_raw;
    end
  end

endmodule

@@ design/iir_df2_fb.sv @@
`include "assert_macros.svh"

module iir_df2_fb #(
  parameter int NTAP = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  iir_df2_pkg::cfg_t                  cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [iir_df2_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output iir_df2_pkg::stage_t                dn_stage
);

  logic                                       s1_valid;
  logic [iir_df2_pkg::SAMPLE_W-1:0]           s1_sample;
  logic [NTAP-1:0][iir_df2_pkg::STATE_W-1:0]  dl;
  logic [iir_df2_pkg::NUM_FB-1:0][iir_df2_pkg::STATE_W-1:0] dv;
  logic                                       adv;

  logic signed [39:0] p_in;
  logic signed [47:0] p_hi [iir_df2_pkg::NUM_FB];
  logic signed [40:0] p_lo [iir_df2_pkg::NUM_FB];
  logic signed [49:0] hi_sum;
  logic signed [42:0] lo_sum;
  logic signed [66:0] total;
  logic [19:0]        frac;
  logic               inc;
  logic signed [47:0] w_round;
  logic [iir_df2_pkg::STATE_W-1:0] w_sat;

  // Input register
  assign in_ready = !s1_valid || dn_ready;
  assign adv      = s1_valid && dn_ready;
  assign dn_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample <= in_sample;
    end
  end

  // Taps beyond the stored depth read as zero
  for (genvar j = 0; j < iir_df2_pkg::NUM_FB; j++) begin : g_view
    if (j < NTAP) begin : g_live
      assign dv[j] = dl[j];
    end else begin : g_pad
      assign dv[j] = '0;
    end
  end

  // Feedback sum, exact at Q36: each tap split into high word and low 16 bits
  always_comb begin
    p_in   = $signed(s1_sample) * $signed(cfg.input_scale);
    hi_sum = 50'(p_in);
    lo_sum = '0;
    for (int j = 0; j < iir_df2_pkg::NUM_FB; j++) begin
      if (3'(j) < cfg.order) begin
        p_hi[j] = $signed(cfg.fb_coef[j]) * $signed(dv[j][39:16]);
        p_lo[j] = $signed(cfg.fb_coef[j]) * $signed({1'b0, dv[j][15:0]});
      end else begin
        p_hi[j] = '0;
        p_lo[j] = '0;
      end
      hi_sum = hi_sum + 50'(p_hi[j]);
      lo_sum = lo_sum + 43'(p_lo[j]);
    end
    total = (67'(hi_sum) <<< 16) + 67'(lo_sum);
  end

  // Round Q36 to Q16, ties to even, then saturate to 40 bits
  always_comb begin
    frac    = total[19:0];
    inc     = (frac > 20'h8_0000) || ((frac == 20'h8_0000) && total[20]);
    w_round = 48'($signed(total[66:20])) + $signed({47'b0, inc});
    priority if (w_round > iir_df2_pkg::W_MAX) begin
      w_sat = iir_df2_pkg::W_MAX[iir_df2_pkg::STATE_W-1:0];
    end else if (w_round < iir_df2_pkg::W_MIN) begin
      w_sat = iir_df2_pkg::W_MIN[iir_df2_pkg::STATE_W-1:0];
    end else begin
      w_sat = w_round[iir_df2_pkg::STATE_W-1:0];
    end
  end

  assign dn_stage.d = dv;
  assign dn_stage.w = w_sat;

  // Delay line: shift toward the oldest end, w enters at order-1
  for (genvar j = 0; j < NTAP; j++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) begin
        dl[j] <= '0;
      end else if (adv) begin
        if (3'(j) == cfg.order - 3'd1) begin
          dl[j] <= w_sat;
        end else if (3'(j) < cfg.order - 3'd1) begin
          if (j < NTAP - 1) begin
            dl[j] <= dl[(j < NTAP - 1) ? j + 1 : j];
          end
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_dl_reset, rst |=> (dl == '0), "delay line not cleared by reset")
  `ASSERT_CLK(a_dl_hold, !adv |=> $stable(dl), "delay line moved without a beat")
  `ASSERT_CLK(a_s1_hold, s1_valid && !dn_ready |=> s1_valid && $stable(s1_sample), "input stage lost a stalled beat")

endmodule

@@ design/iir_df2_out.sv @@
`include "assert_macros.svh"

module iir_df2_out (
  input  logic                               clk,
  input  logic                               rst,
  input  iir_df2_pkg::cfg_t                  cfg,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  iir_df2_pkg::stage_t                up_stage,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [iir_df2_pkg::SAMPLE_W-1:0]   out_sample
);

  logic                 s2_valid;
  iir_df2_pkg::stage_t  s2;
  logic                 o_ready;

  logic signed [39:0] ph;
  logic signed [32:0] pl;
  logic signed [57:0] prod;
  logic signed [57:0] taps4;
  logic signed [57:0] res;
  logic               inc;
  logic signed [42:0] y_round;
  logic [iir_df2_pkg::SAMPLE_W-1:0] y_sat;

  assign o_ready  = !out_valid || out_ready;
  assign up_ready = !s2_valid || o_ready;

  // Stage register holding the taps and w of one beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (up_ready) begin
      s2_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s2 <= up_stage;
    end
  end

  // Numerator: middle tap product split like the feedback, or binomial 4,6,4
  always_comb begin
    ph    = $signed(cfg.middle_tap) * $signed(s2.d[1][39:16]);
    pl    = $signed(cfg.middle_tap) * $signed({1'b0, s2.d[1][15:0]});
    prod  = (58'(ph) <<< 16) + 58'(pl);
    taps4 = ((58'($signed(s2.d[1])) + 58'($signed(s2.d[3]))) <<< 2)
          + (58'($signed(s2.d[2])) <<< 2) + (58'($signed(s2.d[2])) <<< 1);
    res   = 58'($signed(s2.d[0])) + 58'($signed(s2.w))
          + ((cfg.order == iir_df2_pkg::ORDER_FULL) ? taps4 : prod);
  end

  // Round Q16 to integer, ties to even, saturate to int16
  always_comb begin
    inc     = (res[15:0] > 16'h8000) || ((res[15:0] == 16'h8000) && res[16]);
    y_round = 43'($signed(res[57:16])) + $signed({42'b0, inc});
    priority if (y_round > iir_df2_pkg::Y_MAX) begin
      y_sat = iir_df2_pkg::Y_MAX[iir_df2_pkg::SAMPLE_W-1:0];
    end else if (y_round < iir_df2_pkg::Y_MIN) begin
      y_sat = iir_df2_pkg::Y_MIN[iir_df2_pkg::SAMPLE_W-1:0];
    end else begin
      y_sat = y_round[iir_df2_pkg::SAMPLE_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && o_ready) begin
      out_sample <= y_sat;
    end
  end

  `ASSERT_CLK(a_out_load, s2_valid && o_ready |=> out_valid, "stage beat not moved to result register")
  `ASSERT_CLK(a_s2_hold, s2_valid && !o_ready |=> s2_valid && $stable(s2), "stage beat lost while stalled")
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_sample), "result beat changed while stalled")

endmodule

@@ design/iir_filter_direct_form_ii.sv @@
// Direct form II IIR filter, one int16 sample per beat.
// Pipeline: input register, stage register, result register.
// Throughput: one beat per cycle unless the output stalls; feedback loop (nine parallel
// multiplies, adder tree, rounding) closes in the cycle that shifts the delay line.
// Reset: synchronous; clears the pipeline, zeroes the delay line, loads register defaults.
module iir_filter_direct_form_ii #(
  parameter int MAX_ORDER = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // [15:0] sample_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // [15:0] sample_out
  input  logic                                cfg_we,
  input  logic [iir_df2_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iir_df2_pkg::COEF_W-1:0]      cfg_wdata
);

  // Stored taps: the order never exceeds four
  localparam int NTAP = (MAX_ORDER < 4) ? MAX_ORDER : 4;

  iir_df2_pkg::cfg_t   cfg;
  iir_df2_pkg::stage_t stage;
  logic                stage_valid;
  logic                stage_ready;

  iir_df2_cfg #(.NTAP(NTAP)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  iir_df2_fb #(.NTAP(NTAP)) u_fb (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .dn_valid  (stage_valid),
    .dn_ready  (stage_ready),
    .dn_stage  (stage)
  );

  iir_df2_out u_out (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (stage_valid),
    .up_ready   (stage_ready),
    .up_stage   (stage),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (m_axis_tdata)
  );

endmodule
